>>> rtl/bps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blob position smoother package
// Shared widths, reset values, register indexes, the control struct and the
// truncating divide by the history depth.
// ----------------------------------------------------------------------------
package bps_pkg;

  // History depth and field widths.
  localparam int HIST_DEPTH = 10;
  localparam int POS_W      = 10;
  localparam int COORD_W    = 11;
  localparam int AREA_W     = 17;
  localparam int THR_W      = 22;
  localparam int CFG_DATA_W = 22;
  localparam int CFG_IDX_W  = 1;
  localparam int SUM_W      = COORD_W + $clog2(HIST_DEPTH);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_AREA = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_THR = 1'b1;

  // Reset values.
  localparam logic [AREA_W-1:0] MIN_AREA_RESET = AREA_W'(150);
  localparam logic [THR_W-1:0]  JUMP_THR_RESET = THR_W'(1000);
  localparam int                MISS_MARKER    = -100;
  localparam logic signed [COORD_W-1:0] MISS_COORD = COORD_W'(MISS_MARKER);
  localparam logic signed [SUM_W-1:0]   SUM_RESET  = SUM_W'(MISS_MARKER * HIST_DEPTH);

  // Reciprocal for the divide by the depth: exact for every magnitude below
  // 2**SUM_W because 2**DIV_K is at least the depth.
  localparam int          DIV_K     = $clog2(HIST_DEPTH);
  localparam int          DIV_SHIFT = SUM_W + DIV_K;
  localparam int          PROD_W    = SUM_W + DIV_SHIFT;
  localparam int unsigned RECIP     = ((1 << DIV_SHIFT) + HIST_DEPTH - 1) / HIST_DEPTH;

  // Per-step control handed to each axis.
  typedef struct packed {
    logic step;
    logic hit;
    logic jump;
  } bps_ctrl_t;

  // Sum divided by the depth, truncated toward zero.
  function automatic logic signed [COORD_W-1:0] div_depth(
    input logic signed [SUM_W-1:0] sum
  );
    logic [SUM_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  quo;
    mag  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    prod = PROD_W'(mag) * PROD_W'(RECIP);
    quo  = prod[DIV_SHIFT+SUM_W-1:DIV_SHIFT];
    return sum[SUM_W-1] ? COORD_W'(-quo) : COORD_W'(quo);
  endfunction

endpackage

>>> rtl/bps_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blob position smoother, one axis
// Holds the position history of one coordinate with its running sum and
// registered mean, and gives the mean after the next shift.
// ----------------------------------------------------------------------------
module bps_axis (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bps_pkg::bps_ctrl_t                  ctrl_i,
  input  logic [bps_pkg::POS_W-1:0]           pos_i,
  output logic signed [bps_pkg::COORD_W-1:0]  mean_o,
  output logic signed [bps_pkg::COORD_W-1:0]  next_mean_o
);
  import bps_pkg::*;

  logic signed [COORD_W-1:0] hist_q [HIST_DEPTH];
  logic signed [COORD_W-1:0] hist_d [HIST_DEPTH];
  logic signed [SUM_W-1:0]   sum_q, sum_d, shift_sum;
  logic signed [COORD_W-1:0] mean_q, mean_d;
  logic signed [COORD_W-1:0] pos_s, shift_val;

  assign pos_s     = COORD_W'(pos_i);
  assign shift_val = ctrl_i.hit ? pos_s : MISS_COORD;

  // Sum after the oldest entry leaves and the new value enters.
  assign shift_sum   = sum_q - SUM_W'(hist_q[HIST_DEPTH-1]) + SUM_W'(shift_val);
  assign next_mean_o = div_depth(shift_sum);
  assign mean_o      = mean_q;

  // Next history: refill on a jump, shift otherwise.
  always_comb begin
    if (ctrl_i.hit && ctrl_i.jump) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_d[i] = pos_s;
      end
      sum_d  = SUM_W'(HIST_DEPTH) * SUM_W'(pos_i);
      mean_d = pos_s;
    end else begin
      hist_d[0] = shift_val;
      for (int i = 1; i < HIST_DEPTH; i++) begin
        hist_d[i] = hist_q[i-1];
      end
      sum_d  = shift_sum;
      mean_d = next_mean_o;
    end
  end

  // History, sum and mean registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_q[i] <= MISS_COORD;
      end
      sum_q  <= SUM_RESET;
      mean_q <= MISS_COORD;
    end else if (ctrl_i.step) begin
      hist_q <= hist_d;
      sum_q  <= sum_d;
      mean_q <= mean_d;
    end
  end

endmodule

>>> rtl/blob_position_smoother.sv
`timescale 1ns / 1ps
// Pipeline: input register, then result register. Throughput: one
// transaction per cycle while the result side does not stall; the history
// mean is kept registered, so the jump test and the next mean each fit in
// the one compute stage. Reset: history to the miss marker, held position
// to zero, min_area to 150 and jump_threshold to 1000; both stages empty.
// ----------------------------------------------------------------------------
// Blob position smoother
// Filters per-frame blob centroid reports with a moving average over the
// recent history and resets the history when the blob jumps far away.
// ----------------------------------------------------------------------------
module blob_position_smoother (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                contour_found_i,
  input  logic [bps_pkg::AREA_W-1:0]          blob_area_i,
  input  logic [bps_pkg::POS_W-1:0]           pos_x_i,
  input  logic [bps_pkg::POS_W-1:0]           pos_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [bps_pkg::COORD_W-1:0]  smooth_x_o,
  output logic signed [bps_pkg::COORD_W-1:0]  smooth_y_o,
  output logic                                visible_o,
  input  logic                                cfg_we_i,
  input  logic [bps_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bps_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import bps_pkg::*;

  localparam int DX_W   = COORD_W + 1;
  localparam int DIST_W = 2 * DX_W + 1;

  logic              in_vld_q;
  logic              found_q;
  logic [AREA_W-1:0] area_q;
  logic [POS_W-1:0]  px_q, py_q;
  logic              out_vld_q;
  logic              visible_q;
  logic signed [COORD_W-1:0] smooth_x_q, smooth_x_d;
  logic signed [COORD_W-1:0] smooth_y_q, smooth_y_d;
  logic [AREA_W-1:0] min_area_q;
  logic [THR_W-1:0]  jump_thr_q;

  logic              in_take, adv, hit, jump;
  logic signed [COORD_W-1:0] mean_x, mean_y, next_mean_x, next_mean_y;
  logic signed [DX_W-1:0]    dx, dy;
  logic signed [2*DX_W-1:0]  sq_x, sq_y;
  logic [DIST_W-1:0]         dist_sq;
  bps_ctrl_t                 ctrl;

  // Handshake: the compute stage advances when the result register is free.
  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_area_q <= MIN_AREA_RESET;
      jump_thr_q <= JUMP_THR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_AREA: min_area_q <= cfg_data_i[AREA_W-1:0];
        CFG_JUMP_THR: jump_thr_q <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      found_q <= contour_found_i;
      area_q  <= blob_area_i;
      px_q    <= pos_x_i;
      py_q    <= pos_y_i;
    end
  end

  // Detection and jump test against the registered history mean.
  assign hit     = found_q && (area_q > min_area_q);
  assign dx      = DX_W'(mean_x) - DX_W'(px_q);
  assign dy      = DX_W'(mean_y) - DX_W'(py_q);
  assign sq_x    = dx * dx;
  assign sq_y    = dy * dy;
  assign dist_sq = DIST_W'($unsigned(sq_x)) + DIST_W'($unsigned(sq_y));
  assign jump    = hit && (dist_sq > DIST_W'(jump_thr_q));

  assign ctrl.step = adv;
  assign ctrl.hit  = hit;
  assign ctrl.jump = jump;

  bps_axis u_axis_x (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .pos_i       (px_q),
    .mean_o      (mean_x),
    .next_mean_o (next_mean_x)
  );

  bps_axis u_axis_y (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .pos_i       (py_q),
    .mean_o      (mean_y),
    .next_mean_o (next_mean_y)
  );

  // Output position: the point on a jump, the new mean on a hit, else held.
  always_comb begin
    if (!hit) begin
      smooth_x_d = smooth_x_q;
      smooth_y_d = smooth_y_q;
    end else if (jump) begin
      smooth_x_d = COORD_W'(px_q);
      smooth_y_d = COORD_W'(py_q);
    end else begin
      smooth_x_d = next_mean_x;
      smooth_y_d = next_mean_y;
    end
  end

  // Result register; the held position doubles as the last output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      visible_q  <= 1'b0;
      smooth_x_q <= '0;
      smooth_y_q <= '0;
    end else if (adv) begin
      out_vld_q  <= 1'b1;
      visible_q  <= hit;
      smooth_x_q <= smooth_x_d;
      smooth_y_q <= smooth_y_d;
    end else if (!out_stall_i) begin
      out_vld_q  <= 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign visible_o   = visible_q;
  assign smooth_x_o  = smooth_x_q;
  assign smooth_y_o  = smooth_y_q;

endmodule

>>> rtl/bps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blob position smoother checker
// Watches the top-level ports for stall, latency and held-position behavior.
// ----------------------------------------------------------------------------
module bps_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [bps_pkg::COORD_W-1:0]  smooth_x_o,
  input logic signed [bps_pkg::COORD_W-1:0]  smooth_y_o,
  input logic                                visible_o
);
  import bps_pkg::*;

  logic signed [COORD_W-1:0] last_x_q, last_y_q;

  // Position of the last delivered transaction; zero after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q <= '0;
      last_y_q <= '0;
    end else if (out_valid_o && !out_stall_i) begin
      last_x_q <= smooth_x_o;
      last_y_q <= smooth_y_o;
    end
  end

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(smooth_x_o) && $stable(smooth_y_o) && $stable(visible_o))
    else $error("stalled result changed");

  // The input side stalls only behind a stalled, waiting result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the result path was free");

  // Taken with the result register empty, a transaction shows after both registers.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |-> ##2 out_valid_o)
    else $error("result missing two cycles after input");

  // A miss repeats the position of the previous result.
  a_miss_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !visible_o |-> smooth_x_o == last_x_q && smooth_y_o == last_y_q)
    else $error("miss did not hold the last position");

endmodule

bind blob_position_smoother bps_checker u_bps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .smooth_x_o  (smooth_x_o),
  .smooth_y_o  (smooth_y_o),
  .visible_o   (visible_o)
);

>>> tb/blob_position_smoother_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blob position smoother testbench
// Drives blob reports through the valid/stall input channel and checks every
// smoothed position against a local model of the history filter. A short
// table of directed reports covers the area and distance boundaries. Random
// phases follow under several register settings. Both channels idle and
// stall at random, and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module blob_position_smoother_tb;
  import bps_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 200;
  localparam int AREA_MAX   = (1 << AREA_W) - 1;
  localparam int POS_MAX    = (1 << POS_W) - 1;
  localparam int EXP_DEPTH  = 16;
  localparam int DIR_ROWS   = 32;

  // One blob report as offered on the input channel.
  typedef struct packed {
    logic              found;
    logic [AREA_W-1:0] area;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
  } blob_report_t;

  // One smoothed position as given out on the result channel.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      vis;
  } smooth_pos_t;

  // One row of the directed table; want is used only where typed is set.
  typedef struct packed {
    blob_report_t rpt;
    logic         typed;
    smooth_pos_t  want;
  } dir_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic                      contour_found_i;
  logic [AREA_W-1:0]         blob_area_i;
  logic [POS_W-1:0]          pos_x_i;
  logic [POS_W-1:0]          pos_y_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [COORD_W-1:0] smooth_x_o;
  logic signed [COORD_W-1:0] smooth_y_o;
  logic                      visible_o;
  logic                      cfg_we_i;
  logic [CFG_IDX_W-1:0]      cfg_idx_i;
  logic [CFG_DATA_W-1:0]     cfg_data_i;

  // Local copy of the filter state and the registers.
  logic signed [COORD_W-1:0] hist_x [HIST_DEPTH];
  logic signed [COORD_W-1:0] hist_y [HIST_DEPTH];
  logic signed [COORD_W-1:0] held_x;
  logic signed [COORD_W-1:0] held_y;
  logic [AREA_W-1:0]         min_area_cfg;
  logic [THR_W-1:0]          jump_cfg;

  // Expected positions in order of acceptance, kept in a ring.
  smooth_pos_t  exp_pos [EXP_DEPTH];
  int           exp_wr      = 0;
  int           exp_rd      = 0;
  dir_row_t     dir_rows [DIR_ROWS];
  int           dir_count   = 0;
  int           mismatches  = 0;
  int           idle_cycles = 0;
  int           rx_count    = 0;
  bit           tx_steady   = 1'b0;
  bit           rx_steady   = 1'b0;
  int           track_x     = 512;
  int           track_y     = 512;

  blob_position_smoother dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .contour_found_i (contour_found_i),
    .blob_area_i     (blob_area_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .smooth_x_o      (smooth_x_o),
    .smooth_y_o      (smooth_y_o),
    .visible_o       (visible_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Mean of one history axis, truncated toward zero.
  function automatic int hist_mean(input bit y_axis);
    int acc;
    int i;
    acc = 0;
    for (i = 0; i < HIST_DEPTH; i++) begin
      acc += y_axis ? int'(hist_y[i]) : int'(hist_x[i]);
    end
    return acc / HIST_DEPTH;
  endfunction

  // Advances the local filter by one report and returns the position it gives.
  function automatic smooth_pos_t track_blob(input blob_report_t rpt);
    int          px;
    int          py;
    int          dx;
    int          dy;
    longint      dist2;
    int          i;
    smooth_pos_t res;
    px = rpt.x;
    py = rpt.y;
    res.vis = rpt.found && (rpt.area > min_area_cfg);
    if (res.vis) begin
      dx = hist_mean(1'b0) - px;
      dy = hist_mean(1'b1) - py;
      dist2 = longint'(dx * dx) + longint'(dy * dy);
      if (dist2 > longint'(jump_cfg)) begin
        // The blob jumped: restart the history at the new point.
        for (i = 0; i < HIST_DEPTH; i++) begin
          hist_x[i] = COORD_W'(px);
          hist_y[i] = COORD_W'(py);
        end
        held_x = COORD_W'(px);
        held_y = COORD_W'(py);
      end else begin
        for (i = HIST_DEPTH - 1; i > 0; i--) begin
          hist_x[i] = hist_x[i-1];
          hist_y[i] = hist_y[i-1];
        end
        hist_x[0] = COORD_W'(px);
        hist_y[0] = COORD_W'(py);
        held_x = COORD_W'(hist_mean(1'b0));
        held_y = COORD_W'(hist_mean(1'b1));
      end
    end else begin
      // A miss pushes the marker and repeats the held position.
      for (i = HIST_DEPTH - 1; i > 0; i--) begin
        hist_x[i] = hist_x[i-1];
        hist_y[i] = hist_y[i-1];
      end
      hist_x[0] = COORD_W'(MISS_MARKER);
      hist_y[0] = COORD_W'(MISS_MARKER);
    end
    res.x = held_x;
    res.y = held_y;
    return res;
  endfunction

  function automatic void add_row(input bit found, input int area, input int x,
                                  input int y, input bit typed, input int ex,
                                  input int ey, input bit ev);
    dir_row_t row;
    row.rpt.found = found;
    row.rpt.area  = AREA_W'(area);
    row.rpt.x     = POS_W'(x);
    row.rpt.y     = POS_W'(y);
    row.typed     = typed;
    row.want.x    = COORD_W'(ex);
    row.want.y    = COORD_W'(ey);
    row.want.vis  = ev;
    dir_rows[dir_count] = row;
    dir_count++;
  endfunction

  // Random report: mostly a blob drifting around a track, with some teleports,
  // misses, undersized blobs and pure noise.
  function automatic blob_report_t random_report();
    blob_report_t rpt;
    int           sel;
    int           span;
    sel = $urandom_range(0, 15);
    if (sel == 0) begin
      track_x = $urandom_range(0, POS_MAX);
      track_y = $urandom_range(0, POS_MAX);
    end else begin
      track_x += (sel == 3) ? int'($urandom_range(0, 120)) - 60
                            : int'($urandom_range(0, 16)) - 8;
      track_y += int'($urandom_range(0, 16)) - 8;
    end
    if (track_x < 0) track_x = 0;
    if (track_x > POS_MAX) track_x = POS_MAX;
    if (track_y < 0) track_y = 0;
    if (track_y > POS_MAX) track_y = POS_MAX;
    rpt.found = 1'b1;
    rpt.x     = POS_W'(track_x);
    rpt.y     = POS_W'(track_y);
    if (sel == 1) begin
      rpt.found = 1'b0;
      rpt.area  = AREA_W'($urandom());
      rpt.x     = POS_W'($urandom());
      rpt.y     = POS_W'($urandom());
    end else if (sel == 2) begin
      rpt.area = AREA_W'($urandom_range(0, min_area_cfg));
    end else if (min_area_cfg == AREA_W'(AREA_MAX)) begin
      rpt.area = AREA_W'($urandom());
    end else begin
      span = AREA_MAX - 1 - int'(min_area_cfg);
      if ($urandom_range(0, 3) != 0 && span > 300) span = 300;
      rpt.area = min_area_cfg + AREA_W'(1) + AREA_W'($urandom_range(0, span));
    end
    return rpt;
  endfunction

  // Offers one report after a random gap and records its expected position.
  task automatic send_report(input blob_report_t rpt, input bit typed,
                             input smooth_pos_t want);
    int          gap;
    smooth_pos_t pred;
    if ($urandom_range(0, 31) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    contour_found_i <= rpt.found;
    blob_area_i     <= rpt.area;
    pos_x_i         <= rpt.x;
    pos_y_i         <= rpt.y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = track_blob(rpt);
    exp_pos[exp_wr % EXP_DEPTH] = typed ? want : pred;
    exp_wr++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] word);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= word;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MIN_AREA) min_area_cfg = word[AREA_W-1:0];
    else jump_cfg = word[THR_W-1:0];
  endtask

  // Stops offering and waits until every expected position has come back.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] area_word,
                           input logic [CFG_DATA_W-1:0] thr_word, input int count);
    int          n;
    smooth_pos_t none;
    none = '0;
    settle();
    write_reg(CFG_MIN_AREA, area_word);
    write_reg(CFG_JUMP_THR, thr_word);
    for (n = 0; n < count; n++) send_report(random_report(), 1'b0, none);
  endtask

  // Stimulus: reset, directed table, then random phases.
  initial begin
    int i;
    int k;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    contour_found_i = 1'b0;
    blob_area_i     = '0;
    pos_x_i         = '0;
    pos_y_i         = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_MIN_AREA;
    cfg_data_i      = '0;
    min_area_cfg    = MIN_AREA_RESET;
    jump_cfg        = JUMP_THR_RESET;
    held_x          = '0;
    held_y          = '0;
    for (i = 0; i < HIST_DEPTH; i++) begin
      hist_x[i] = COORD_W'(MISS_MARKER);
      hist_y[i] = COORD_W'(MISS_MARKER);
    end

    // Miss right after reset repeats the zero position.
    add_row(0, 0, 0, 0, 1, 0, 0, 0);
    // Area equal to the minimum is rejected.
    add_row(1, 150, 1023, 1023, 1, 0, 0, 0);
    // First detection is far from the marker history and restarts it.
    add_row(1, 151, 0, 0, 1, 0, 0, 1);
    add_row(1, AREA_MAX, 1023, 1023, 1, 1023, 1023, 1);
    // Distance exactly at the threshold is smoothed, not restarted.
    add_row(1, 200, 993, 1013, 0, 0, 0, 0);
    add_row(1, 300, 1020, 1021, 0, 0, 0, 0);
    // Not found, even with a large area, and a plain miss.
    add_row(0, AREA_MAX, 1023, 1023, 0, 0, 0, 0);
    add_row(0, 0, 512, 512, 0, 0, 0, 0);
    // Opposite corners: both far from the mean, so each restarts the history.
    add_row(1, 151, 1023, 0, 1, 1023, 0, 1);
    add_row(1, 151, 0, 1023, 1, 0, 1023, 1);
    add_row(1, 152, 0, 1023, 0, 0, 0, 0);
    add_row(1, 500, 0, 0, 1, 0, 0, 1);
    add_row(1, 500, 30, 10, 0, 0, 0, 0);
    add_row(1, 500, 40, 20, 1, 40, 20, 1);
    // Three misses drive the mean negative; the next point truncates toward zero.
    add_row(1, 0, 1023, 1023, 0, 0, 0, 0);
    add_row(0, 77, 5, 5, 0, 0, 0, 0);
    add_row(1, 149, 0, 0, 0, 0, 0, 0);
    add_row(1, 500, 3, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 0, 0, 0, 0);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (k = 0; k < dir_count; k++) begin
      send_report(dir_rows[k].rpt, dir_rows[k].typed, dir_rows[k].want);
    end

    // Every found report with a nonzero area is a hit, every nonzero distance restarts.
    run_phase(CFG_DATA_W'(0), CFG_DATA_W'(0), 300);
    // Nothing can exceed the area limit; the upper data bits are dropped.
    run_phase({CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}}, 100);
    // No distance can exceed the largest threshold, so the filter always smooths.
    run_phase(CFG_DATA_W'(1000), {CFG_DATA_W{1'b1}}, 350);
    run_phase(CFG_DATA_W'($urandom_range(0, 3000)),
              CFG_DATA_W'($urandom_range(0, 20000)), 500);
    run_phase(CFG_DATA_W'(MIN_AREA_RESET), CFG_DATA_W'(JUMP_THR_RESET), 550);

    settle();
    if (mismatches == 0) begin
      $display("** blob_position_smoother: PASSED **");
    end else begin
      $display("** blob_position_smoother: FAILED **");
    end
    $finish;
  end

  // Result side: random stall per transaction, plus one long hold-off.
  initial begin
    int hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_steady = !rx_steady;
      hold = rx_steady ? 0 : $urandom_range(0, 11);
      if (rx_count == 500) hold = LONG_HOLD;
      if (hold > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (hold - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      rx_count++;
    end
  end

  // Result check and watchdog.
  always @(posedge clk_i) begin
    smooth_pos_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (exp_wr == exp_rd) begin
          $display("%0t: unexpected result x=%0d y=%0d vis=%0b", $time,
                   smooth_x_o, smooth_y_o, visible_o);
          mismatches++;
        end else begin
          want = exp_pos[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (smooth_x_o !== want.x || smooth_y_o !== want.y || visible_o !== want.vis) begin
            $display("%0t: mismatch: expected x=%0d y=%0d vis=%0b, got x=%0d y=%0d vis=%0b",
                     $time, want.x, want.y, want.vis, smooth_x_o, smooth_y_o, visible_o);
            mismatches++;
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("** blob_position_smoother: FAILED **");
        $finish;
      end
    end
  end

endmodule

>>> sim.f
rtl/bps_pkg.sv
rtl/bps_axis.sv
rtl/blob_position_smoother.sv
rtl/bps_checker.sv
tb/blob_position_smoother_tb.sv
